[hdl/mcfe_pkg.sv]
// mcfe_pkg: constants, byte positions and crc step for the motor command frame encoder
// no dependencies; used by motor_command_frame_encoder, mcfe_checker and the test bench
package mcfe_pkg;

    localparam int unsigned FRAME_LEN = 9;
    localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

    localparam logic [7:0]  FRAME_SOF  = 8'hFF;
    localparam logic [7:0]  FRAME_ID   = 8'h07;
    localparam logic [15:0] CRC_SEED   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    // byte positions inside a frame
    localparam logic [IDX_W-1:0] POS_SOF     = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_ID      = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_LEFT_LO = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_LEFT_HI = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_RGHT_LO = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_RGHT_HI = IDX_W'(5);
    localparam logic [IDX_W-1:0] POS_CTRL    = IDX_W'(6);
    localparam logic [IDX_W-1:0] POS_CRC_LO  = IDX_W'(7);
    localparam logic [IDX_W-1:0] POS_CRC_HI  = IDX_W'(8);

    localparam logic ACTION_MOVE = 1'b0;
    localparam logic ACTION_STOP = 1'b1;

    typedef struct packed {
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic [7:0]         direction_code;
        logic               action;
    } cmd_t;

    // reflected crc-16 update over one byte, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

[hdl/motor_command_frame_encoder.sv]
// motor_command_frame_encoder: turns one motor command into a 9-byte frame with crc-16/modbus
// depends on mcfe_pkg
//
// channel   dir  tdata (low bit up)                                   tuser   tlast
// s_*       in   left_speed[15:0] right_speed[31:16] direction[39:32] action  -
// m_*       out  frame_byte[7:0]                                      -       last byte
//
// one command gives nine byte transfers, one per cycle unless m_tready stalls; the byte
// serializer sets the sustained command rate.
// a one-entry input buffer takes the next command while the current frame is sent.
// the crc is built one byte per cycle, paused by m_tready stalls, as bytes 1 to 6 leave the serializer.
// reset clears the buffer, serializer and output valid; no frame is in flight after it.
// a stall on m_tready holds the output byte and pauses the serializer.
module motor_command_frame_encoder
    import mcfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // left_speed[15:0], right_speed[31:16], direction_code[39:32]
    input  logic        s_tuser,   // action[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // frame_byte[7:0]
    output logic        m_tlast    // last_byte
);

    logic             pend_valid_reg, pend_valid_next;
    cmd_t             pend_reg, pend_next;
    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    cmd_t             cmd_reg, cmd_next;
    logic [15:0]      crc_reg, crc_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;

    logic             in_xfer;
    logic             emit;
    logic             finish;
    logic             load;
    logic [7:0]       cur_byte;

    assign s_tready = !pend_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;
    assign emit     = busy_reg && (!out_valid_reg || m_tready);
    assign finish   = emit && (idx_reg == POS_CRC_HI);
    assign load     = pend_valid_reg && (!busy_reg || finish);

    always_comb
    begin
        unique case (idx_reg)
            POS_SOF:     cur_byte = FRAME_SOF;
            POS_ID:      cur_byte = FRAME_ID;
            POS_LEFT_LO: cur_byte = cmd_reg.left_speed[7:0];
            POS_LEFT_HI: cur_byte = cmd_reg.left_speed[15:8];
            POS_RGHT_LO: cur_byte = cmd_reg.right_speed[7:0];
            POS_RGHT_HI: cur_byte = cmd_reg.right_speed[15:8];
            POS_CTRL:    cur_byte = cmd_reg.direction_code + 8'd1;
            POS_CRC_LO:  cur_byte = crc_reg[7:0];
            POS_CRC_HI:  cur_byte = crc_reg[15:8];
            default:     cur_byte = 8'h00;
        endcase
        // stop frame: everything after the id byte is zero
        if (cmd_reg.action == ACTION_STOP && idx_reg != POS_SOF && idx_reg != POS_ID)
        begin
            cur_byte = 8'h00;
        end
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        busy_next       = busy_reg;
        idx_next        = idx_reg;
        cmd_next        = cmd_reg;
        crc_next        = crc_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;

        if (load)
        begin
            pend_valid_next = 1'b0;
        end
        if (in_xfer)
        begin
            pend_valid_next        = 1'b1;
            pend_next.left_speed     = s_tdata[15:0];
            pend_next.right_speed    = s_tdata[31:16];
            pend_next.direction_code = s_tdata[39:32];
            pend_next.action         = s_tuser;
        end

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = cur_byte;
            out_last_next  = (idx_reg == POS_CRC_HI);
            idx_next       = idx_reg + IDX_W'(1);
            if (idx_reg != POS_SOF && idx_reg < POS_CRC_LO)
            begin
                crc_next = crc_byte(crc_reg, cur_byte);
            end
            if (finish)
            begin
                busy_next = 1'b0;
            end
        end

        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = POS_SOF;
            cmd_next  = pend_reg;
            crc_next  = CRC_SEED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            busy_reg       <= 1'b0;
            idx_reg        <= POS_SOF;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            busy_reg       <= busy_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        cmd_reg      <= cmd_next;
        crc_reg      <= crc_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

[hdl/mcfe_checker.sv]
// mcfe_checker: port-level checks on frame layout and output handshake
// depends on mcfe_pkg; bound to motor_command_frame_encoder
module mcfe_checker
    import mcfe_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             out_xfer;

    assign out_xfer = m_tvalid && m_tready;

    always_comb
    begin
        pos_next = pos_reg;
        if (out_xfer)
        begin
            pos_next = m_tlast ? POS_SOF : pos_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_SOF;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // stalled output transfer holds its byte
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output byte changed under stall");

    a_sof: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && pos_reg == POS_SOF |-> m_tdata == FRAME_SOF)
        else $error("frame does not open with start byte");

    a_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && pos_reg == POS_ID |-> m_tdata == FRAME_ID)
        else $error("second frame byte is not the id byte");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tlast == (pos_reg == POS_CRC_HI))
        else $error("tlast not on ninth byte");

endmodule

bind motor_command_frame_encoder mcfe_checker u_mcfe_checker (.*);

[dv/motor_command_frame_encoder_test.sv]
// motor_command_frame_encoder_test: self-checking bench for the motor command frame encoder
// drives directed and random commands with random gaps and stalls, predicts each 9-byte frame
// depends on mcfe_pkg and motor_command_frame_encoder

typedef struct packed {
    logic [7:0] data;
    logic       last;
} frame_byte_t;

class frame_byte_checker;
    frame_byte_t queued_bytes[$];
    int          errors;
    int          bytes_checked;
    int          move_count;
    int          stop_count;
    int          byte_pos;

    function new();
        errors        = 0;
        bytes_checked = 0;
        move_count    = 0;
        stop_count    = 0;
        byte_pos      = 0;
    endfunction

    // predict the frame for one accepted command transfer
    function void add_command(mcfe_pkg::cmd_t cmd);
        logic [7:0]  frame [mcfe_pkg::FRAME_LEN];
        logic [15:0] crc;
        frame_byte_t entry;
        frame[0] = mcfe_pkg::FRAME_SOF;
        frame[1] = mcfe_pkg::FRAME_ID;
        if (cmd.action == mcfe_pkg::ACTION_STOP)
        begin
            stop_count++;
            for (int k = 2; k < mcfe_pkg::FRAME_LEN; k++)
            begin
                frame[k] = 8'h00;
            end
        end
        else
        begin
            move_count++;
            frame[2] = cmd.left_speed[7:0];
            frame[3] = cmd.left_speed[15:8];
            frame[4] = cmd.right_speed[7:0];
            frame[5] = cmd.right_speed[15:8];
            frame[6] = cmd.direction_code + 8'd1;
            // reflected crc over the id byte up to the control byte
            crc = mcfe_pkg::CRC_SEED;
            for (int k = 1; k <= 6; k++)
            begin
                crc = crc ^ {8'h00, frame[k]};
                for (int b = 0; b < 8; b++)
                begin
                    if (crc[0])
                    begin
                        crc = (crc >> 1) ^ mcfe_pkg::CRC_POLY;
                    end
                    else
                    begin
                        crc = crc >> 1;
                    end
                end
            end
            frame[7] = crc[7:0];
            frame[8] = crc[15:8];
        end
        for (int k = 0; k < mcfe_pkg::FRAME_LEN; k++)
        begin
            entry.data = frame[k];
            entry.last = (k == mcfe_pkg::FRAME_LEN - 1);
            queued_bytes.push_back(entry);
        end
    endfunction

    function void check_byte(logic [7:0] data, logic last);
        frame_byte_t want;
        if (queued_bytes.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected byte transfer: expected none, actual %02h last %0b",
                     $time, data, last);
            return;
        end
        want = queued_bytes.pop_front();
        bytes_checked++;
        if (data !== want.data)
        begin
            errors++;
            $display("%0t: frame byte %0d: expected %02h, actual %02h",
                     $time, byte_pos, want.data, data);
        end
        if (last !== want.last)
        begin
            errors++;
            $display("%0t: last flag on byte %0d: expected %0b, actual %0b",
                     $time, byte_pos, want.last, last);
        end
        byte_pos = (byte_pos + 1) % mcfe_pkg::FRAME_LEN;
    endfunction

    function int pending();
        return queued_bytes.size();
    endfunction
endclass

module motor_command_frame_encoder_test;
    import mcfe_pkg::*;

    localparam int RANDOM_COMMANDS = 300;
    localparam int CYCLE_LIMIT     = 200000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    frame_byte_checker frame_check;
    bit                no_idle;
    int                cycle_count = 0;

    motor_command_frame_encoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // one command transfer, after a random gap with s_tvalid low
    task automatic send_command(input logic action, input logic [15:0] left,
                                input logic [15:0] right, input logic [7:0] dir);
        cmd_t cmd;
        int   gap;
        cmd.action         = action;
        cmd.left_speed     = left;
        cmd.right_speed    = right;
        cmd.direction_code = dir;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cmd.direction_code, cmd.right_speed, cmd.left_speed};
        s_tuser  <= cmd.action;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        frame_check.add_command(cmd);
    endtask

    function automatic logic [15:0] pick_speed();
        logic [15:0] speed;
        case ($urandom_range(0, 7))
            0:       speed = 16'h8000;
            1:       speed = 16'h7FFF;
            2:       speed = 16'hFFFF;
            3:       speed = 16'h0000;
            default: speed = 16'($urandom);
        endcase
        return speed;
    endfunction

    // byte sink with random stalls on m_tready
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_tvalid);
            frame_check.check_byte(m_tdata, m_tlast);
        end
    end

    initial
    begin
        logic        action;
        logic [7:0]  dir;
        logic [7:0]  dir_pick [4];
        frame_check = new();
        no_idle     = 1'b0;
        dir_pick    = '{8'd80, 8'd0, 8'd64, 8'd16};
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: speed extremes, helper direction codes, wrap of the control byte, stops
        send_command(ACTION_MOVE, 16'h0000, 16'h0000, 8'd0);
        send_command(ACTION_MOVE, 16'h7FFF, 16'h8000, 8'd80);
        send_command(ACTION_MOVE, 16'h8000, 16'h7FFF, 8'd64);
        send_command(ACTION_MOVE, 16'hFFFF, 16'hFFFF, 8'd16);
        send_command(ACTION_MOVE, 16'h0001, 16'hFFFE, 8'd255);
        send_command(ACTION_MOVE, 16'hFF00, 16'h00FF, 8'd254);
        send_command(ACTION_STOP, 16'h0000, 16'h0000, 8'd0);
        send_command(ACTION_STOP, 16'hFFFF, 16'hFFFF, 8'd255);
        send_command(ACTION_STOP, 16'h1234, 16'h8000, 8'd80);
        send_command(ACTION_MOVE, 16'h1234, 16'hABCD, 8'd127);
        no_idle = 1'b1;
        send_command(ACTION_MOVE, 16'hFFFF, 16'h0000, 8'd255);
        send_command(ACTION_STOP, 16'h5555, 16'hAAAA, 8'd85);
        send_command(ACTION_MOVE, 16'hAAAA, 16'h5555, 8'd170);
        send_command(ACTION_MOVE, 16'h8000, 16'h8000, 8'd128);
        no_idle = 1'b0;

        for (int n = 0; n < RANDOM_COMMANDS; n++)
        begin
            // every fourth stretch of 30 commands runs with no gaps or stalls
            no_idle = ((n / 30) % 4) == 3;
            action  = ($urandom_range(0, 9) == 0) ? ACTION_STOP : ACTION_MOVE;
            dir     = ($urandom_range(0, 3) == 0) ? dir_pick[$urandom_range(0, 3)]
                                                  : 8'($urandom_range(0, 255));
            send_command(action, pick_speed(), pick_speed(), dir);
        end
        s_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (frame_check.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        $display("covered %0d move and %0d stop commands, %0d frame bytes compared",
                 frame_check.move_count, frame_check.stop_count, frame_check.bytes_checked);
        $display("random gaps and stalls of 0 to 5 cycles, with gap-free stretches");
        if (frame_check.errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
hdl/mcfe_pkg.sv
hdl/motor_command_frame_encoder.sv
hdl/mcfe_checker.sv
dv/motor_command_frame_encoder_test.sv
